// File: src/swept_box_time_of_impact_unit_defines.svh
// Assertion macros for the swept box time-of-impact unit.
// Needs clk and arst_n in the scope of each use; no other dependencies.
`ifndef SWEPT_BOX_TIME_OF_IMPACT_UNIT_DEFINES_SVH
`define SWEPT_BOX_TIME_OF_IMPACT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SBTOI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBTOI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/sbtoi_pkg.sv
// Shared widths and codes for the swept box time-of-impact unit.
// No dependencies.
package sbtoi_pkg;

	localparam int COORD_W    = 32;            // Q16.16 centers
	localparam int FRAC_W     = 16;            // fraction bits of times
	localparam int SAT_LOG    = 15;            // slab time magnitude saturates at 2^15
	localparam int HALF_W     = COORD_W - 1;   // half extents
	localparam int AXIS_W     = 2;
	localparam int EPS_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = EPS_W;

	localparam int LR_W   = COORD_W + 2;       // slab bounds, signed
	localparam int DIR_W  = COORD_W + 2;       // relative motion, signed
	localparam int NUM_W  = COORD_W + 3;       // bound minus start, signed
	localparam int DMAG_W = DIR_W;             // divisor magnitude
	localparam int NMAG_W = NUM_W;             // dividend magnitude
	localparam int QB     = SAT_LOG + FRAC_W;  // quotient bits below saturation
	localparam int MAG_W  = QB + 1;            // time magnitude incl. saturation code
	localparam int TIME_W = MAG_W + 1;         // signed time
	localparam int CNT_W  = $clog2(QB);
	localparam int ET_W   = FRAC_W + 1;        // entry time output, Q1.FRAC

	localparam logic signed [TIME_W-1:0] TIME_NEG_INF = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic signed [TIME_W-1:0] TIME_POS_INF = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic signed [TIME_W-1:0] TIME_ONE     = TIME_W'(1) << FRAC_W;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TWO_D_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 1'd1;

	localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PREP1 = 8'b0000_0010,
		S_PREP2 = 8'b0000_0100,
		S_PREP3 = 8'b0000_1000,
		S_LOAD  = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_STORE = 8'b0100_0000,
		S_FOLD  = 8'b1000_0000
	} state_t;

endpackage

// File: src/swept_box_time_of_impact_unit.sv
// Swept box time-of-impact unit: slab test on relative motion, one axis per item.
// Uses sbtoi_pkg and swept_box_time_of_impact_unit_defines.svh.
// One item at a time: an ignored axis ends in PREP1, a stationary axis in PREP3, and a
// moving axis runs two 31-step passes of one shared restoring divider, where a pass
// whose slab time saturates skips the divide. A last item adds a result register load.
// Async active-low reset clears control, pair state and config (epsilon to 66).
`include "swept_box_time_of_impact_unit_defines.svh"

module swept_box_time_of_impact_unit
	import sbtoi_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration writes
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	// input items
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [AXIS_W-1:0]           axis,
	input  logic                        last,
	input  logic signed [COORD_W-1:0]   a_prev,
	input  logic signed [COORD_W-1:0]   a_curr,
	input  logic signed [COORD_W-1:0]   b_prev,
	input  logic signed [COORD_W-1:0]   b_curr,
	input  logic [HALF_W-1:0]           a_half_extent,
	input  logic [HALF_W-1:0]           b_half_extent,
	// result items
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [ET_W-1:0]             entry_time,
	output logic [AXIS_W-1:0]           hit_axis
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic             two_d_q;
	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_d_q <= 1'b0;
			eps_q   <= EPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TWO_D_MODE: two_d_q <= cfg_data[0];
				REG_EPSILON:    eps_q   <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer and pair state
	// ---------------------------------------------------------------
	state_t                    state_q;
	logic                      pass_q;        // 0: left bound, 1: right bound
	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;        // result waiting for a free output slot
	logic                      rejected_q;
	logic                      any_motion_q;
	logic signed [TIME_W-1:0]  run_entry_q;
	logic signed [TIME_W-1:0]  run_exit_q;
	logic [AXIS_W-1:0]         entry_axis_q;
	logic                      out_valid_q;

	// captured item
	logic [AXIS_W-1:0]         axis_q;
	logic                      last_q;
	logic                      used_q;
	logic signed [COORD_W-1:0] a_prev_q, a_curr_q, b_prev_q, b_curr_q;
	logic [HALF_W-1:0]         ha_q, hb_q;

	// prep datapath
	logic signed [LR_W-1:0]    ext_q, left_q, right_q;
	logic signed [DIR_W-1:0]   db_q, da_q, dir_q;
	logic signed [NUM_W-1:0]   numl_q, numr_q;
	logic [DMAG_W-1:0]         d_q;
	logic                      dir_neg_q;

	// divider
	logic                      neg_q, sat_q;
	logic [DMAG_W-1:0]         r_q;
	logic [QB-1:0]             nb_q;          // dividend bits still to shift in
	logic [QB-1:0]             q_q;
	logic signed [TIME_W-1:0]  t0_q, t1_q;

	// output payload
	logic                      hit_q;
	logic [ET_W-1:0]           entry_time_q;
	logic [AXIS_W-1:0]         hit_axis_q;

	// ---------------------------------------------------------------
	// Combinational helpers
	// ---------------------------------------------------------------
	logic                      used_c;
	logic [DMAG_W-1:0]         dmag;
	logic                      still, outside;
	logic signed [NUM_W-1:0]   num_sel;
	logic [NMAG_W-1:0]         nmag;
	logic                      sat_c;
	logic [DMAG_W:0]           rs, diff;
	logic                      ge;
	logic [MAG_W-1:0]          tmag;
	logic signed [TIME_W-1:0]  t_val, te, tx;
	logic                      slot_free, hit_c, idle_c;

	assign idle_c = (state_q == S_IDLE) && !done_q;
	assign in_ready = idle_c;
	assign slot_free = !out_valid_q || out_ready;

	// z is ignored in 2D mode; axis code three is never used
	assign used_c = (axis == AXIS_X) || (axis == AXIS_Y) || ((axis == AXIS_Z) && !two_d_q);

	assign dmag = dir_q[DIR_W-1] ? DMAG_W'(-dir_q) : DMAG_W'(dir_q);
	assign still = dmag <= DMAG_W'(eps_q);
	assign outside = (LR_W'(b_prev_q) < left_q) || (LR_W'(b_prev_q) > right_q);

	assign num_sel = pass_q ? numr_q : numl_q;
	assign nmag = num_sel[NUM_W-1] ? NMAG_W'(-num_sel) : NMAG_W'(num_sel);
	// integer quotient of 2^15 or more saturates
	assign sat_c = (DMAG_W + SAT_LOG)'(nmag) >= {d_q, {SAT_LOG{1'b0}}};

	// one restoring step: remainder stays below the divisor
	assign rs = {r_q, nb_q[QB-1]};
	assign ge = rs >= {1'b0, d_q};
	assign diff = rs - {1'b0, d_q};

	assign tmag = sat_q ? {1'b1, {QB{1'b0}}} : {1'b0, q_q};
	assign t_val = neg_q ? -TIME_W'(tmag) : TIME_W'(tmag);

	assign te = (t0_q < t1_q) ? t0_q : t1_q;
	assign tx = (t0_q < t1_q) ? t1_q : t0_q;

	assign hit_c = !rejected_q && any_motion_q && (run_entry_q <= run_exit_q) &&
		!run_entry_q[TIME_W-1] && (run_entry_q <= TIME_ONE);

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pass_q       <= 1'b0;
			cnt_q        <= '0;
			done_q       <= 1'b0;
			rejected_q   <= 1'b0;
			any_motion_q <= 1'b0;
			run_entry_q  <= TIME_NEG_INF;
			run_exit_q   <= TIME_POS_INF;
			entry_axis_q <= AXIS_X;
			out_valid_q  <= 1'b0;
		end else begin
			// result register: load on pair end, drop when taken
			if (done_q && slot_free) begin
				out_valid_q  <= 1'b1;
				done_q       <= 1'b0;
				rejected_q   <= 1'b0;
				any_motion_q <= 1'b0;
				run_entry_q  <= TIME_NEG_INF;
				run_exit_q   <= TIME_POS_INF;
				entry_axis_q <= AXIS_X;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid && idle_c) begin
						state_q <= S_PREP1;
					end
				end
				S_PREP1: begin
					if (!used_q) begin
						done_q  <= last_q;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PREP2;
					end
				end
				S_PREP2: state_q <= S_PREP3;
				S_PREP3: begin
					if (still) begin
						if (outside) begin
							rejected_q <= 1'b1;
						end
						done_q  <= last_q;
						state_q <= S_IDLE;
					end else begin
						pass_q  <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= sat_c ? S_STORE : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QB - 1)) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (!pass_q) begin
						pass_q  <= 1'b1;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					any_motion_q <= 1'b1;
					// strict compare: ties keep the earlier axis
					if (te > run_entry_q) begin
						run_entry_q  <= te;
						entry_axis_q <= axis_q;
					end
					if (tx < run_exit_q) begin
						run_exit_q <= tx;
					end
					done_q  <= last_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers (no reset)
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (done_q && slot_free) begin
			hit_q        <= hit_c;
			entry_time_q <= hit_c ? run_entry_q[ET_W-1:0] : '0;
			hit_axis_q   <= hit_c ? entry_axis_q : AXIS_X;
		end

		case (state_q)
			S_IDLE: begin
				if (in_valid && idle_c) begin
					axis_q   <= axis;
					last_q   <= last;
					used_q   <= used_c;
					a_prev_q <= a_prev;
					a_curr_q <= a_curr;
					b_prev_q <= b_prev;
					b_curr_q <= b_curr;
					ha_q     <= a_half_extent;
					hb_q     <= b_half_extent;
				end
			end
			S_PREP1: begin
				ext_q <= LR_W'(ha_q) + LR_W'(hb_q);
				db_q  <= DIR_W'(b_curr_q) - DIR_W'(b_prev_q);
				da_q  <= DIR_W'(a_curr_q) - DIR_W'(a_prev_q);
			end
			S_PREP2: begin
				left_q  <= LR_W'(a_prev_q) - ext_q;
				right_q <= LR_W'(a_prev_q) + ext_q;
				dir_q   <= db_q - da_q;
			end
			S_PREP3: begin
				numl_q    <= NUM_W'(left_q) - NUM_W'(b_prev_q);
				numr_q    <= NUM_W'(right_q) - NUM_W'(b_prev_q);
				d_q       <= dmag;
				dir_neg_q <= dir_q[DIR_W-1];
			end
			S_LOAD: begin
				neg_q <= num_sel[NUM_W-1] ^ dir_neg_q;
				sat_q <= sat_c;
				r_q   <= DMAG_W'(nmag >> SAT_LOG);
				nb_q  <= {nmag[SAT_LOG-1:0], {FRAC_W{1'b0}}};
			end
			S_DIV: begin
				r_q  <= ge ? DMAG_W'(diff) : DMAG_W'(rs);
				q_q  <= {q_q[QB-2:0], ge};
				nb_q <= nb_q << 1;
			end
			S_STORE: begin
				if (!pass_q) begin
					t0_q <= t_val;
				end else begin
					t1_q <= t_val;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign entry_time = entry_time_q;
	assign hit_axis   = hit_axis_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`SBTOI_ASSERT_NOW(a_div_rem_below, state_q == S_DIV, r_q < d_q, "divider remainder not below divisor")
	`SBTOI_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "item accepted while busy")
	`SBTOI_ASSERT_NOW(a_result_from_pair_end, $rose(out_valid), $past(done_q), "result without pair end")
	`SBTOI_ASSERT_NOW(a_miss_is_zero, out_valid && !hit, entry_time == '0 && hit_axis == AXIS_X, "miss carries nonzero fields")
	`SBTOI_ASSERT_NOW(a_hit_time_range, out_valid && hit, entry_time <= ET_W'(TIME_ONE), "hit time above one")

endmodule

// File: dv/swept_box_time_of_impact_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for swept_box_time_of_impact_unit: drives axis items with random
// gaps, folds each accepted item into a slab-test predictor, checks every contact result.
// Depends on sbtoi_pkg and the unit's RTL.

module swept_box_time_of_impact_unit_test;
	import sbtoi_pkg::*;

	localparam longint      UNIT         = longint'(1) << FRAC_W;  // 1.0 in Q16.16
	localparam longint      NO_LIMIT     = longint'(1) << (SAT_LOG + 1 + FRAC_W);
	localparam longint      COORD_MAX    = 64'sd2147483647;
	localparam longint      COORD_MIN    = -64'sd2147483648;
	localparam longint      HALF_MAX     = 64'sd2147483647;
	localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;             // unused axis code
	localparam int          SETTLE_CYCLES = 150;                // > one moving item plus result load
	localparam int          HOLD_AFTER   = 25;                  // results seen before the long stall
	localparam int          HOLD_CYCLES  = 2500;
	localparam int unsigned CYCLE_LIMIT  = 800000;

	typedef struct {
		logic [AXIS_W-1:0]         axis;
		logic                      last;
		logic signed [COORD_W-1:0] a_prev;
		logic signed [COORD_W-1:0] a_curr;
		logic signed [COORD_W-1:0] b_prev;
		logic signed [COORD_W-1:0] b_curr;
		logic [HALF_W-1:0]         a_half;
		logic [HALF_W-1:0]         b_half;
	} axis_item_t;

	typedef struct {
		logic              hit;
		logic [ET_W-1:0]   entry_time;
		logic [AXIS_W-1:0] hit_axis;
	} contact_t;

	// DUT ports, all inputs known from time zero
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [AXIS_W-1:0]         axis = '0;
	logic                      last = 1'b0;
	logic signed [COORD_W-1:0] a_prev = '0;
	logic signed [COORD_W-1:0] a_curr = '0;
	logic signed [COORD_W-1:0] b_prev = '0;
	logic signed [COORD_W-1:0] b_curr = '0;
	logic [HALF_W-1:0]         a_half_extent = '0;
	logic [HALF_W-1:0]         b_half_extent = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      hit;
	logic [ET_W-1:0]           entry_time;
	logic [AXIS_W-1:0]         hit_axis;

	// stimulus and expectations
	axis_item_t pending_items[$];
	contact_t   pending_contacts[$];
	axis_item_t on_wire;
	bit         no_idle = 1'b0;      // when set, neither side inserts gaps
	int         mismatches = 0;
	int         results_seen = 0;
	int         send_gap = 0;
	int         recv_wait = 0;
	int         hold_left = 0;
	int unsigned cycle_count = 0;

	// register shadows, updated only while the unit is idle
	logic             two_d_shadow = 1'b0;
	logic [EPS_W-1:0] eps_shadow = EPS_RESET;

	// running pair state of the predictor
	longint            pair_entry = -NO_LIMIT;
	longint            pair_exit = NO_LIMIT;
	logic [AXIS_W-1:0] pair_axis = AXIS_X;
	bit                pair_rejected = 1'b0;
	bit                pair_moved = 1'b0;

	swept_box_time_of_impact_unit dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// (num / den) in Q.FRAC_W: magnitude truncated, sign applied last,
	// saturated at 2^SAT_LOG whole units
	function automatic longint slab_time(input longint num, input longint den);
		bit [63:0] n, d, q, r, m;
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = n / d;
		r = n % d;
		if (q >= (64'd1 << SAT_LOG)) begin
			m = (64'd1 << SAT_LOG) << FRAC_W;
		end else begin
			m = q;
			for (int i = 0; i < FRAC_W; i++) begin
				r = r << 1;
				m = m << 1;
				if (r >= d) begin
					r = r - d;
					m[0] = 1'b1;
				end
			end
		end
		return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
	endfunction

	// fold one accepted axis item into the pair; a last item yields one contact result
	task automatic fold_axis_item(input axis_item_t it);
		longint   ext, lo, hi, start, motion, t0, t1, te, tx;
		contact_t res;
		if (it.axis <= AXIS_Z && !(two_d_shadow && it.axis == AXIS_Z)) begin
			ext    = longint'(it.a_half) + longint'(it.b_half);
			lo     = longint'(it.a_prev) - ext;
			hi     = longint'(it.a_prev) + ext;
			start  = longint'(it.b_prev);
			motion = (longint'(it.b_curr) - start) - (longint'(it.a_curr) - longint'(it.a_prev));
			if (((motion < 0) ? -motion : motion) <= longint'(eps_shadow)) begin
				// stationary: only a start outside the slab matters
				if (start < lo || start > hi)
					pair_rejected = 1'b1;
			end else begin
				t0 = slab_time(lo - start, motion);
				t1 = slab_time(hi - start, motion);
				te = (t0 < t1) ? t0 : t1;
				tx = (t0 < t1) ? t1 : t0;
				pair_moved = 1'b1;
				// strict compare: a tie keeps the earlier axis
				if (te > pair_entry) begin
					pair_entry = te;
					pair_axis  = it.axis;
				end
				if (tx < pair_exit)
					pair_exit = tx;
			end
		end
		if (it.last) begin
			res.hit = !pair_rejected && pair_moved && pair_entry <= pair_exit &&
			          pair_entry >= 0 && pair_entry <= UNIT;
			res.entry_time = res.hit ? pair_entry[ET_W-1:0] : '0;
			res.hit_axis   = res.hit ? pair_axis : AXIS_X;
			pending_contacts.push_back(res);
			pair_entry    = -NO_LIMIT;
			pair_exit     = NO_LIMIT;
			pair_axis     = AXIS_X;
			pair_rejected = 1'b0;
			pair_moved    = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic int draw_wait();
		return no_idle ? 0 : int'($urandom_range(0, 19));
	endfunction

	// uniform in [-r, r]
	function automatic longint spread(input longint r);
		return longint'($urandom_range(0, 32'(2 * r))) - r;
	endfunction

	task automatic add_item(input logic [AXIS_W-1:0] ax, input logic lst,
	                        input longint ap, input longint ac, input longint bp,
	                        input longint bc, input longint ha, input longint hb);
		axis_item_t it;
		it.axis   = ax;
		it.last   = lst;
		it.a_prev = ap[COORD_W-1:0];
		it.a_curr = ac[COORD_W-1:0];
		it.b_prev = bp[COORD_W-1:0];
		it.b_curr = bc[COORD_W-1:0];
		it.a_half = ha[HALF_W-1:0];
		it.b_half = hb[HALF_W-1:0];
		pending_items.push_back(it);
	endtask

	// One axis item with random content. Most are small boxes that sweep through
	// each other, so entry times land in and around [0,1]; the rest are near-stationary
	// (including exactly epsilon and epsilon+1), far and slow (saturation), or raw bits.
	task automatic add_axis_item(input logic [AXIS_W-1:0] ax, input logic lst);
		longint      ha, hb, ext, ap, ac, bp, bc, shift, wob;
		int unsigned style;
		style = $urandom_range(0, 9);
		if (style == 9 || ax == AXIS_NONE) begin
			add_item(ax, lst, $urandom, $urandom, $urandom, $urandom,
			         $urandom >> 1, $urandom >> 1);
		end else begin
			ha    = $urandom_range(0, 1 << 18);
			hb    = $urandom_range(0, 1 << 18);
			ext   = ha + hb;
			ap    = spread(1 << 22);
			shift = spread(1 << 17);
			ac    = ap + shift;
			if (style == 8) begin
				bp = ap + spread(1 << 30);
				bc = bp + shift + eps_shadow + 1 + $urandom_range(0, 15);
			end else begin
				bp = ap + spread(3 * ext + (1 << 16));
				if (style >= 6) begin
					case ($urandom_range(0, 3))
						0: wob = eps_shadow;
						1: wob = -longint'(eps_shadow);
						2: wob = longint'(eps_shadow) + 1;
						default: wob = spread(eps_shadow);
					endcase
					bc = bp + shift + wob;
				end else begin
					bc = bp + shift + spread(4 * ext + (1 << 17));
				end
			end
			add_item(ax, lst, ap, ac, bp, bc, ha, hb);
		end
	endtask

	// A pair test: mostly x, y (, z) ending in last; some with random axis order and
	// repeats, some with an unused axis code inside, a few bursts of loose noise.
	task automatic add_random_pair();
		logic [AXIS_W-1:0] seq[$];
		int unsigned       mode;
		mode = $urandom_range(0, 19);
		if (mode == 0) begin
			repeat ($urandom_range(1, 4))
				add_axis_item(AXIS_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		end else begin
			if (mode == 1) begin
				repeat ($urandom_range(1, 4))
					seq.push_back(AXIS_W'($urandom_range(0, 2)));
			end else begin
				seq.push_back(AXIS_X);
				seq.push_back(AXIS_Y);
				if (!two_d_shadow || $urandom_range(0, 3) == 0)
					seq.push_back(AXIS_Z);
			end
			if (mode == 2)
				seq.insert($urandom_range(0, seq.size()), AXIS_NONE);
			foreach (seq[k])
				add_axis_item(seq[k], k == seq.size() - 1);
		end
	endtask

	task automatic add_random_items(input int count);
		int target;
		target = pending_items.size() + count;
		while (pending_items.size() < target)
			add_random_pair();
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TWO_D_MODE)
			two_d_shadow = val[0];
		else
			eps_shadow = val;
	endtask

	// everything queued accepted and answered; sampled away from the active edge
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || pending_contacts.size() != 0)
			@(negedge clk);
	endtask

	// new register values only once the unit has finished its last item
	task automatic set_config(input logic two_d, input logic [EPS_W-1:0] eps);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_TWO_D_MODE, CFG_DATA_W'(two_d));
		write_reg(REG_EPSILON, eps);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// 3D, default epsilon written explicitly
		set_config(1'b0, EPS_RESET);
		// basic hit on x at t = 0.5, y and z stationary and overlapping
		add_item(AXIS_X, 1'b0, 0, 0, -4 * UNIT, 0, UNIT, UNIT);
		add_item(AXIS_Y, 1'b0, 0, 0, 0, 0, UNIT, UNIT);
		add_item(AXIS_Z, 1'b1, 0, 0, 0, 0, UNIT, UNIT);
		// entry exactly at 1.0, exactly at 0, and moving in the negative direction
		add_item(AXIS_X, 1'b1, 0, 0, -4 * UNIT, -2 * UNIT, UNIT, UNIT);
		add_item(AXIS_X, 1'b1, 0, 0, -2 * UNIT, 2 * UNIT, UNIT, UNIT);
		add_item(AXIS_X, 1'b1, 0, 0, 4 * UNIT, 0, UNIT, UNIT);
		// later entry on y wins
		add_item(AXIS_X, 1'b0, 0, 0, -4 * UNIT, 0, UNIT, UNIT);
		add_item(AXIS_Y, 1'b1, 0, 0, -8 * UNIT, 0, UNIT, UNIT);
		// equal entry on x and y keeps x
		add_item(AXIS_X, 1'b0, 0, 0, -4 * UNIT, 0, UNIT, UNIT);
		add_item(AXIS_Y, 1'b1, 0, 0, -4 * UNIT, 0, UNIT, UNIT);
		// stationary x outside its slab rejects an otherwise good pair
		add_item(AXIS_X, 1'b0, 0, 0, 10 * UNIT, 10 * UNIT, UNIT, UNIT);
		add_item(AXIS_Y, 1'b1, 0, 0, -4 * UNIT, 0, UNIT, UNIT);
		// no motion at all: miss
		add_item(AXIS_X, 1'b1, 0, 0, 0, 0, 0, 0);
		// unused axis code carries the last flag, its data ignored
		add_item(AXIS_X, 1'b0, 0, 0, -4 * UNIT, 0, UNIT, UNIT);
		add_item(AXIS_NONE, 1'b1, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, HALF_MAX, 0);
		// same axis twice in one pair
		add_item(AXIS_X, 1'b0, 0, 0, -4 * UNIT, 0, UNIT, UNIT);
		add_item(AXIS_X, 1'b1, 0, 0, -8 * UNIT, 0, UNIT, UNIT);
		// slow motion from far away saturates both slab times
		add_item(AXIS_X, 1'b1, 0, 0, COORD_MIN, COORD_MIN + EPS_RESET + 1, 0, 0);
		// field extremes
		add_item(AXIS_Z, 1'b1, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, HALF_MAX, HALF_MAX);
		add_item(AXIS_Y, 1'b1, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0);
		// motion of exactly epsilon is stationary, y carries the hit
		add_item(AXIS_X, 1'b0, 0, 0, 0, EPS_RESET, UNIT, UNIT);
		add_item(AXIS_Y, 1'b1, 0, 0, -4 * UNIT, 0, UNIT, UNIT);

		// 2D with zero epsilon: z items ignored, any motion counts
		set_config(1'b1, '0);
		add_item(AXIS_X, 1'b0, 0, 0, -4 * UNIT, 0, UNIT, UNIT);
		add_item(AXIS_Z, 1'b1, 0, 0, -8 * UNIT, 0, UNIT, UNIT);
		add_item(AXIS_Z, 1'b1, 0, 0, -4 * UNIT, 0, UNIT, UNIT);
		add_item(AXIS_X, 1'b1, 0, 0, 0, 1, UNIT, UNIT);
		add_random_items(300);

		// 3D, largest epsilon, no gaps on either side
		set_config(1'b0, '1);
		no_idle = 1'b1;
		add_random_items(300);

		// 2D, random epsilon
		set_config(1'b1, EPS_W'($urandom));
		no_idle = 1'b0;
		add_random_items(300);

		// back to reset values
		set_config(1'b0, EPS_RESET);
		add_random_items(350);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: one item on the bus at a time, held until accepted, then a random, possibly empty, gap
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				fold_axis_item(on_wire);
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap = send_gap - 1;
				end else if (pending_items.size() > 0) begin
					on_wire       = pending_items.pop_front();
					axis          <= on_wire.axis;
					last          <= on_wire.last;
					a_prev        <= on_wire.a_prev;
					a_curr        <= on_wire.a_curr;
					b_prev        <= on_wire.b_prev;
					b_curr        <= on_wire.b_curr;
					a_half_extent <= on_wire.a_half;
					b_half_extent <= on_wire.b_half;
					offer         = 1'b1;
					send_gap      = draw_wait();
				end
			end
			in_valid <= offer;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result against the oldest expectation and
	// throttles out_ready; one long hold-off lets the unit back up
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		contact_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_contacts.size() == 0) begin
					$error("contact result with nothing expected");
					mismatches++;
				end else begin
					want = pending_contacts.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						mismatches++;
					end
					if (entry_time !== want.entry_time) begin
						$error("entry_time: expected %0d, got %0d", want.entry_time, entry_time);
						mismatches++;
					end
					if (hit_axis !== want.hit_axis) begin
						$error("hit_axis: expected %0d, got %0d", want.hit_axis, hit_axis);
						mismatches++;
					end
				end
				results_seen++;
				recv_wait = draw_wait();
				if (results_seen == HOLD_AFTER)
					hold_left = HOLD_CYCLES;
			end
			out_ready <= (hold_left == 0 && recv_wait == 0);
			if (hold_left > 0)
				hold_left--;
			else if (recv_wait > 0)
				recv_wait--;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
